@@ rtl/core/pxq_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pxq_pkg
// Shared constants and controller/datapath interface types for the
// prefix-XOR range query block.
// -----------------------------------------------------------------------------
package pxq_pkg;

   // storage and word size
   localparam int DEPTH      = 1024;
   localparam int WORD_BITS  = 32;

   // fixed field widths
   localparam int VALUE_BITS = 32;
   localparam int INDEX_BITS = 11;

   // derived widths
   localparam int DATA_BITS  = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int CMP_BITS   = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;
   localparam int ACALC_BITS = (ADDR_BITS > INDEX_BITS) ? ADDR_BITS : INDEX_BITS;

   // command codes
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_FLIP  = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic start;
      logic load;
      logic flip_issue;
      logic flip_hi;
      logic flip_lo;
      logic query;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic load_ok;
      logic flip_ok;
      logic left_gt_one;
      logic rsp_busy;
   } dp_status_type;

endpackage

@@ rtl/core/pxq_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pxq_ram
// Generic single-port RAM, one access per cycle, registered read data.
// -----------------------------------------------------------------------------
module pxq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/pxq_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pxq_ctrl
// Request sequencer: takes beats, issues datapath commands and steps the
// one or two prefix-table reads of a flip.
// -----------------------------------------------------------------------------
module pxq_ctrl
   import pxq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_FLIP_HI = 3'b010,
      ST_FLIP_LO = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      idle;
   logic      accept;

   assign idle = (state_ff == ST_IDLE);

   // every request waits during a flip; a query also waits while the previous answer is still held
   assign req_stall = !idle || (status.rsp_busy && (req_cmd == CMD_QUERY));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd            = '0;
      cmd.start      = accept && (req_cmd == CMD_START);
      cmd.load       = accept && (req_cmd == CMD_LOAD) && status.load_ok;
      cmd.flip_issue = accept && (req_cmd == CMD_FLIP) && status.flip_ok;
      cmd.query      = accept && (req_cmd == CMD_QUERY);
      cmd.flip_hi    = (state_ff == ST_FLIP_HI);
      cmd.flip_lo    = (state_ff == ST_FLIP_LO);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.flip_issue) state_in = ST_FLIP_HI;
         end
         ST_FLIP_HI: begin
            state_in = status.left_gt_one ? ST_FLIP_LO : ST_IDLE;
         end
         ST_FLIP_LO: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_hi_after_issue: assert property (@(posedge clock) disable iff (reset)
      cmd.flip_issue |=> cmd.flip_hi)
      else $error("flip read not followed by capture");

   a_lo_needs_left: assert property (@(posedge clock) disable iff (reset)
      cmd.flip_lo |-> $past(cmd.flip_hi) && $past(status.left_gt_one))
      else $error("second flip read without a left prefix");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (cmd.flip_hi || cmd.flip_lo) |-> req_stall)
      else $error("request taken during a flip");

endmodule

@@ rtl/core/pxq_datapath.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pxq_datapath
// Prefix table, running prefix, group and flip accumulators, answer
// register.
// -----------------------------------------------------------------------------
module pxq_datapath
   import pxq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_label,
   input  logic [INDEX_BITS-1:0] req_left_index,
   input  logic [INDEX_BITS-1:0] req_right_index,
   input  logic                  req_group,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_answer,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status
);

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [DATA_BITS-1:0]  last_ff, last_in;
   logic [DATA_BITS-1:0]  g0_ff, g0_in;
   logic [DATA_BITS-1:0]  g1_ff, g1_in;
   logic [DATA_BITS-1:0]  flip_ff, flip_in;
   logic [INDEX_BITS-1:0] left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  answer_ff, answer_in;

   logic [DATA_BITS-1:0]  value_w;
   logic [DATA_BITS-1:0]  prefix_new;
   logic [ACALC_BITS-1:0] right_m1;
   logic [ACALC_BITS-1:0] left_m2;
   logic                  ram_en;
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_addr;
   logic [DATA_BITS-1:0]  ram_rdata;

   assign value_w    = req_value[DATA_BITS-1:0];
   assign prefix_new = last_ff ^ value_w;

   assign right_m1 = ACALC_BITS'(req_right_index) - ACALC_BITS'(1);
   assign left_m2  = ACALC_BITS'(left_ff) - ACALC_BITS'(2);

   always_comb begin
      status             = '0;
      status.load_ok     = (count_ff < CNT_BITS'(DEPTH));
      status.flip_ok     = (req_left_index != '0) &&
                           (req_left_index <= req_right_index) &&
                           (CMP_BITS'(req_right_index) <= CMP_BITS'(count_ff));
      status.left_gt_one = (left_ff > INDEX_BITS'(1));
      status.rsp_busy    = rsp_valid_ff && rsp_stall;
   end

   // port: load writes at count, flip reads right-1 then left-2 (left-2 only when left exceeds one)
   assign ram_we = cmd.load;
   assign ram_en = cmd.load || cmd.flip_issue || (cmd.flip_hi && status.left_gt_one);

   always_comb begin
      if (cmd.load) begin
         ram_addr = count_ff[ADDR_BITS-1:0];
      end else if (cmd.flip_issue) begin
         ram_addr = right_m1[ADDR_BITS-1:0];
      end else begin
         ram_addr = left_m2[ADDR_BITS-1:0];
      end
   end

   pxq_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (prefix_new),
      .rdata (ram_rdata)
   );

   always_comb begin
      count_in = count_ff;
      last_in  = last_ff;
      g0_in    = g0_ff;
      g1_in    = g1_ff;
      flip_in  = flip_ff;
      left_in  = left_ff;
      if (cmd.start) begin
         count_in = '0;
         last_in  = '0;
         g0_in    = '0;
         g1_in    = '0;
         flip_in  = '0;
      end
      if (cmd.load) begin
         count_in = count_ff + CNT_BITS'(1);
         last_in  = prefix_new;
         if (req_label) begin
            g1_in = g1_ff ^ value_w;
         end else begin
            g0_in = g0_ff ^ value_w;
         end
      end
      if (cmd.flip_issue) begin
         left_in = req_left_index;
      end
      if (cmd.flip_hi || cmd.flip_lo) begin
         flip_in = flip_ff ^ ram_rdata;
      end
   end

   assign rsp_valid_in = cmd.query || (rsp_valid_ff && rsp_stall);
   assign answer_in    = cmd.query ? (flip_ff ^ (req_group ? g1_ff : g0_ff)) : answer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_ff      <= '0;
         g0_ff        <= '0;
         g1_ff        <= '0;
         flip_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_ff      <= last_in;
         g0_ff        <= g0_in;
         g1_ff        <= g1_in;
         flip_ff      <= flip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      answer_ff <= answer_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = VALUE_BITS'(answer_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("element count past table depth");

   a_query_free: assert property (@(posedge clock) disable iff (reset)
      cmd.query |-> !(rsp_valid_ff && rsp_stall))
      else $error("query overwrote a held answer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(answer_ff)))
      else $error("stalled answer beat changed");

endmodule

@@ rtl/core/prefix_xor_range_query.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prefix_xor_range_query
// Prefix-XOR table with per-group XOR accumulators and range flips.
// -----------------------------------------------------------------------------
// Usage:
//   Request beats (req_*) carry a command: start clears the set, load appends
//   a word with its group label, flip toggles labels over [left, right], and
//   query asks for the XOR of one group. Only a query returns a response beat
//   (rsp_answer).
//   Start, load, query and a dropped flip leave the sequencer idle; a query answer
//   is valid the cycle after its beat is taken. A flip in range reads the
//   single-port prefix table at right-1 and, unless left_index is one, at
//   left-2, with registered read data; other requests wait until it ends.
//   Loads past the table depth and flips out of range are dropped silently.
//   Reset clears the count, running prefix and accumulators; the table itself
//   is not cleared and is only read at entries already written.
//   The answer sits in an output register: while rsp_stall holds it, other
//   commands are still taken and only a new query waits.
// -----------------------------------------------------------------------------
module prefix_xor_range_query
   import pxq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_label,
   input  logic [INDEX_BITS-1:0] req_left_index,
   input  logic [INDEX_BITS-1:0] req_right_index,
   input  logic                  req_group,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_answer
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pxq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pxq_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .req_label       (req_label),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .req_group       (req_group),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_answer      (rsp_answer),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
